// ----- src/sle_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial line editor package
// Byte classes, result kinds, and datapath command and status types shared
// by the controller and the datapath, and the controller's error text.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int LINE_LEN_DEF = 10;
    localparam int ERR_LEN      = 9;

    // Control characters handled by the editor
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_LO    = 8'h30;
    localparam logic [7:0] CH_HI    = 8'h7a;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Result kinds
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    typedef enum logic [2:0] {
        CLS_IGN,
        CLS_CR,
        CLS_BS,
        CLS_DEL,
        CLS_CHR
    } t_cls;

    typedef enum logic [1:0] {
        VSEL_CONST,
        VSEL_CHAR,
        VSEL_RDATA
    } t_vsel;

    typedef enum logic [1:0] {
        POS_HOLD,
        POS_STORE,
        POS_DEC,
        POS_CLEAR
    } t_pos_op;

    typedef struct packed {
        logic       latch;
        t_pos_op    pos_op;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_en;
        logic       load;
        logic [1:0] kind;
        t_vsel      vsel;
        logic [7:0] cval;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic pos_zero;
        logic pos_full;
        logic idx_done;
        t_cls cls;
    } t_dp_stat;

    // Sort a received byte; newline counts as carriage return
    function automatic t_cls classify(input logic [7:0] c);
        t_cls cls;
        if (c == CH_CR || c == CH_LF) begin
            cls = CLS_CR;
        end else if (c == CH_BS) begin
            cls = CLS_BS;
        end else if (c == CH_DEL) begin
            cls = CLS_DEL;
        end else if (c >= CH_LO && c <= CH_HI) begin
            cls = CLS_CHR;
        end else begin
            cls = CLS_IGN;
        end
        return cls;
    endfunction

    // Error text: CR LF "ERROR" CR LF
    function automatic logic [7:0] err_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = CH_CR;
            4'd1:    c = CH_LF;
            4'd2:    c = 8'h45;
            4'd3:    c = 8'h52;
            4'd4:    c = 8'h52;
            4'd5:    c = 8'h4f;
            4'd6:    c = 8'h52;
            4'd7:    c = CH_CR;
            4'd8:    c = CH_LF;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

// ----- src/sle_dp.sv -----
// ----------------------------------------------------------------------------
// Serial line editor datapath
// Line buffer memory, fill position, read index, latched input byte and the
// result output register.
// ----------------------------------------------------------------------------
module sle_dp #(
    parameter int LINE_LEN = sle_pkg::LINE_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_rx_byte,
    input  sle_pkg::t_dp_cmd  i_cmd,
    output sle_pkg::t_dp_stat o_stat,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_value,
    output logic              o_last
);

    localparam int PW = $clog2(LINE_LEN + 1);
    localparam int AW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;

    logic [7:0]    r_mem [LINE_LEN];
    logic [7:0]    r_rdata;
    logic [7:0]    r_char;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_idx;
    logic          r_valid;
    logic [1:0]    r_kind;
    logic [7:0]    r_value;
    logic          r_last;
    logic [7:0]    n_value;
    logic          pos_full;

    assign pos_full = (r_pos == PW'(LINE_LEN));

    // Status toward the controller
    always_comb begin
        o_stat.out_free = !r_valid || !i_stall;
        o_stat.pos_zero = (r_pos == '0);
        o_stat.pos_full = pos_full;
        o_stat.idx_done = (r_idx == r_pos);
        o_stat.cls      = sle_pkg::classify(i_rx_byte);
    end

    // Store an accepted character while the buffer has room; read the buffer and latch the input byte on command
    always_ff @(posedge i_clk) begin
        if (i_cmd.pos_op == sle_pkg::POS_STORE && !pos_full) begin
            r_mem[r_pos[AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[r_idx[AW-1:0]];
        end
        if (i_cmd.latch) begin
            r_char <= i_rx_byte;
        end
    end

    // Advance fill position and read index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_idx <= '0;
        end else begin
            case (i_cmd.pos_op)
                sle_pkg::POS_STORE: begin
                    if (!pos_full) begin
                        r_pos <= r_pos + PW'(1);
                    end
                end
                sle_pkg::POS_DEC:   r_pos <= r_pos - PW'(1);
                sle_pkg::POS_CLEAR: r_pos <= '0;
                default:            r_pos <= r_pos;
            endcase
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + PW'(1);
            end
        end
    end

    // Select the result value
    always_comb begin
        case (i_cmd.vsel)
            sle_pkg::VSEL_CHAR:  n_value = r_char;
            sle_pkg::VSEL_RDATA: n_value = r_rdata;
            default:             n_value = i_cmd.cval;
        endcase
    end

    // Output register: load a new result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_cmd.kind;
            r_value <= n_value;
            r_last  <= i_cmd.last;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_value = r_value;
    assign o_last  = r_last;

endmodule

// ----- src/sle_ctrl.sv -----
// ----------------------------------------------------------------------------
// Serial line editor controller
// Decodes each accepted byte and steps through the echo, line release and
// error sequences; each step but idle and the buffer read loads one result.
// ----------------------------------------------------------------------------
module sle_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  sle_pkg::t_dp_stat i_stat,
    output sle_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CR_CR,
        S_CR_LF,
        S_RD,
        S_CH,
        S_END,
        S_BS1,
        S_BS2,
        S_BS3,
        S_DEL,
        S_CHR,
        S_ERR
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_err_idx, n_err_idx;
    logic       r_ovf, n_ovf;
    logic       r_busy;

    // Emit one echo result when the output register is free
    function automatic sle_pkg::t_dp_cmd echo_cmd(input logic [7:0] c, input logic lst,
                                                  input logic free);
        sle_pkg::t_dp_cmd cmd;
        cmd       = '0;
        cmd.load  = free;
        cmd.kind  = sle_pkg::KIND_ECHO;
        cmd.vsel  = sle_pkg::VSEL_CONST;
        cmd.cval  = c;
        cmd.last  = lst;
        return cmd;
    endfunction

    always_comb begin
        n_state   = r_state;
        n_err_idx = r_err_idx;
        n_ovf     = r_ovf;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    case (i_stat.cls)
                        sle_pkg::CLS_CR: n_state = S_CR_CR;
                        sle_pkg::CLS_BS: begin
                            if (!i_stat.pos_zero) begin
                                o_cmd.pos_op = sle_pkg::POS_DEC;
                                n_state      = S_BS1;
                            end
                        end
                        sle_pkg::CLS_DEL: begin
                            if (!i_stat.pos_zero) begin
                                o_cmd.pos_op = sle_pkg::POS_DEC;
                                n_state      = S_DEL;
                            end
                        end
                        sle_pkg::CLS_CHR: begin
                            o_cmd.pos_op = i_stat.pos_full ? sle_pkg::POS_CLEAR
                                                           : sle_pkg::POS_STORE;
                            n_ovf        = i_stat.pos_full;
                            n_state      = S_CHR;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CR_CR: begin
                o_cmd = echo_cmd(sle_pkg::CH_CR, 1'b0, i_stat.out_free);
                if (i_stat.out_free) begin
                    n_state = S_CR_LF;
                end
            end
            S_CR_LF: begin
                o_cmd         = echo_cmd(sle_pkg::CH_LF, 1'b0, i_stat.out_free);
                o_cmd.idx_clr = 1'b1;
                if (i_stat.out_free) begin
                    n_state = S_RD;
                end
            end
            // Fetch the next stored character, or finish the line
            S_RD: begin
                if (i_stat.idx_done) begin
                    n_state = S_END;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_CH;
                end
            end
            S_CH: begin
                o_cmd.load    = i_stat.out_free;
                o_cmd.idx_inc = i_stat.out_free;
                o_cmd.kind    = sle_pkg::KIND_CHAR;
                o_cmd.vsel    = sle_pkg::VSEL_RDATA;
                if (i_stat.out_free) begin
                    n_state = S_RD;
                end
            end
            S_END: begin
                o_cmd.load = i_stat.out_free;
                o_cmd.kind = sle_pkg::KIND_END;
                o_cmd.vsel = sle_pkg::VSEL_CONST;
                o_cmd.cval = sle_pkg::CH_NUL;
                o_cmd.last = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.pos_op = sle_pkg::POS_CLEAR;
                    n_state      = S_IDLE;
                end
            end
            S_BS1: begin
                o_cmd = echo_cmd(sle_pkg::CH_BS, 1'b0, i_stat.out_free);
                if (i_stat.out_free) begin
                    n_state = S_BS2;
                end
            end
            S_BS2: begin
                o_cmd = echo_cmd(sle_pkg::CH_SPACE, 1'b0, i_stat.out_free);
                if (i_stat.out_free) begin
                    n_state = S_BS3;
                end
            end
            S_BS3: begin
                o_cmd = echo_cmd(sle_pkg::CH_BS, 1'b1, i_stat.out_free);
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DEL: begin
                o_cmd = echo_cmd(sle_pkg::CH_DEL, 1'b1, i_stat.out_free);
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            // Echo the latched byte; on overflow go on to the error text
            S_CHR: begin
                o_cmd.load = i_stat.out_free;
                o_cmd.kind = sle_pkg::KIND_ECHO;
                o_cmd.vsel = sle_pkg::VSEL_CHAR;
                o_cmd.last = !r_ovf;
                if (i_stat.out_free) begin
                    n_err_idx = '0;
                    n_state   = r_ovf ? S_ERR : S_IDLE;
                end
            end
            S_ERR: begin
                o_cmd = echo_cmd(sle_pkg::err_char(r_err_idx), 1'b0, i_stat.out_free);
                if (i_stat.out_free) begin
                    n_err_idx = r_err_idx + 4'd1;
                    if (r_err_idx == 4'(sle_pkg::ERR_LEN - 1)) begin
                        n_state = S_END;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and the registered stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_err_idx <= '0;
            r_ovf     <= 1'b0;
            r_busy    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_err_idx <= n_err_idx;
            r_ovf     <= n_ovf;
            r_busy    <= (n_state != S_IDLE);
        end
    end

    assign o_stall = r_busy;

endmodule

// ----- src/serial_line_editor.sv -----
// ----------------------------------------------------------------------------
// Serial line editor
// Edits a line buffer from received serial bytes and echoes what it accepts.
// ----------------------------------------------------------------------------
// Timing: an accepted byte sets the controller state, and the first result is
// then loaded into the output register. Throughput: one echo result per cycle
// while the output is not stalled; each released line character takes a buffer
// read, then an output load, and the block stalls input until the line is out.
// Reset: synchronous, active low; empties the line, buffer contents undefined.
// ----------------------------------------------------------------------------
module serial_line_editor #(
    parameter int LINE_LEN = sle_pkg::LINE_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_value,
    output logic       o_last
);

    sle_pkg::t_dp_cmd  cmd;
    sle_pkg::t_dp_stat stat;

    sle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    sle_dp #(
        .LINE_LEN (LINE_LEN)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx_byte (i_rx_byte),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_kind    (o_kind),
        .o_value   (o_value),
        .o_last    (o_last)
    );

endmodule
